// ===== design/ttb_pkg.sv =====
// Shared widths, constants and types of the triangle tangent/binormal datapath.
package ttb_pkg;

    // Texture coordinate fields: two signed Q4.12 halves in one 32-bit word.
    localparam int UV_W  = 16;
    localparam int UVP_W = 2 * UV_W;

    // Unit vector output format, signed Q2.14.
    localparam int UNIT_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int UNIT_ONE  = 16384;

    // Normalized magnitudes have their leading one at bit SCALE_W-1.
    localparam int SCALE_W = 30;
    localparam int SQ_W    = 2 * SCALE_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int QUOT_W  = FRAC_BITS + 1;
    localparam int NUM_W   = ROOT_W + QUOT_W - 1;

    // Pipeline depth of the front end and of the fixed part of a vector unit.
    localparam int FRONT_STAGES      = 4;
    localparam int UNIT_FIXED_STAGES = 4 + ROOT_W + QUOT_W;

    // Sign bits and zero-length mark that travel with a vector.
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } vec_tag_t;

    // What rides alongside the square root: the scaled magnitudes and the tag.
    typedef struct packed {
        vec_tag_t                 tag;
        logic [2:0][SCALE_W-1:0] s;
    } sq_pay_t;

    // Status of one finished vector.
    typedef struct packed {
        logic valid;
        logic degenerate;
    } unit_status_t;

endpackage

// ===== design/triangle_tangent_binormal.sv =====
// Top level of the triangle tangent/binormal unit.
//
// One request is one triangle: three vertex positions (p0..p2, signed Q8.8,
// COORD_WIDTH bits each) and three packed texture coordinates (v in bits
// 31:16, u in bits 15:0, both signed Q4.12). A request is taken at every
// rising edge where start is high and busy is low. The datapath is a fully
// pipelined chain with no back-pressure, so busy is held low and a new
// triangle may be issued on every clock cycle.
//
// Each request yields exactly one result: the unit tangent and unit
// binormal in signed Q2.14, plus a degenerate flag per vector that is set
// when that vector had zero length (its components are then zero). A
// result is shown for one cycle with done high; the receiver cannot stall,
// so it must take the result in that cycle.
//
// The depth is set by the front end, the leading-one normalizer, the square
// root (one root bit per stage) and the divider (one quotient bit per stage).
// Reset clears every valid bit, so requests in flight at reset are dropped
// and done stays low until new requests arrive.
module triangle_tangent_binormal
    import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  p0_x,
    input  logic signed [COORD_WIDTH-1:0]  p0_y,
    input  logic signed [COORD_WIDTH-1:0]  p0_z,
    input  logic signed [COORD_WIDTH-1:0]  p1_x,
    input  logic signed [COORD_WIDTH-1:0]  p1_y,
    input  logic signed [COORD_WIDTH-1:0]  p1_z,
    input  logic signed [COORD_WIDTH-1:0]  p2_x,
    input  logic signed [COORD_WIDTH-1:0]  p2_y,
    input  logic signed [COORD_WIDTH-1:0]  p2_z,
    input  logic [UVP_W-1:0]               uv0_packed,
    input  logic [UVP_W-1:0]               uv1_packed,
    input  logic [UVP_W-1:0]               uv2_packed,
    output logic                           done,
    output logic signed [UNIT_W-1:0]       tan_x,
    output logic signed [UNIT_W-1:0]       tan_y,
    output logic signed [UNIT_W-1:0]       tan_z,
    output logic signed [UNIT_W-1:0]       bin_x,
    output logic signed [UNIT_W-1:0]       bin_y,
    output logic signed [UNIT_W-1:0]       bin_z,
    output logic                           tan_degenerate,
    output logic                           bin_degenerate
);

    // Width of the raw cross-product magnitudes, and the resulting depth.
    localparam int MAG_W       = COORD_WIDTH + UV_W + 3;
    localparam int NORM_W      = (MAG_W > SCALE_W) ? MAG_W : SCALE_W;
    localparam int NORM_STAGES = $clog2(NORM_W);
    localparam int LATENCY     = FRONT_STAGES + NORM_STAGES + UNIT_FIXED_STAGES;

    // The pipeline never stalls, so every start is taken.
    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    logic [2:0][2:0][COORD_WIDTH-1:0] pos;
    logic [2:0][UVP_W-1:0]            uv;

    assign pos[0][0] = p0_x;
    assign pos[0][1] = p0_y;
    assign pos[0][2] = p0_z;
    assign pos[1][0] = p1_x;
    assign pos[1][1] = p1_y;
    assign pos[1][2] = p1_z;
    assign pos[2][0] = p2_x;
    assign pos[2][1] = p2_y;
    assign pos[2][2] = p2_z;
    assign uv[0]     = uv0_packed;
    assign uv[1]     = uv1_packed;
    assign uv[2]     = uv2_packed;

    // Front end: edges, UV deltas and the two unnormalized vectors.
    logic                   fe_valid;
    logic [2:0][MAG_W-1:0]  tan_mag, bin_mag;
    logic [2:0]             tan_neg, bin_neg;

    ttb_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pos       (pos),
        .uv        (uv),
        .out_valid (fe_valid),
        .tan_mag   (tan_mag),
        .tan_neg   (tan_neg),
        .bin_mag   (bin_mag),
        .bin_neg   (bin_neg)
    );

    // Two identical normalizers run side by side, so their outputs line up.
    unit_status_t            tan_st, bin_st;
    logic [2:0][UNIT_W-1:0]  tan_comp, bin_comp;

    ttb_unit #(
        .MW (MAG_W)
    ) u_tan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fe_valid),
        .mag      (tan_mag),
        .neg      (tan_neg),
        .status   (tan_st),
        .comp     (tan_comp)
    );

    ttb_unit #(
        .MW (MAG_W)
    ) u_bin (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fe_valid),
        .mag      (bin_mag),
        .neg      (bin_neg),
        .status   (bin_st),
        .comp     (bin_comp)
    );

    assign done           = tan_st.valid;
    assign tan_x          = tan_comp[0];
    assign tan_y          = tan_comp[1];
    assign tan_z          = tan_comp[2];
    assign bin_x          = bin_comp[0];
    assign bin_y          = bin_comp[1];
    assign bin_z          = bin_comp[2];
    assign tan_degenerate = tan_st.degenerate;
    assign bin_degenerate = bin_st.degenerate;

    // The two normalizers must stay in lockstep.
    a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        tan_st.valid == bin_st.valid)
        else $error("tangent and binormal results are out of step");

    // Every result traces back to a request a fixed latency earlier.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching request");

    // A zero-length vector reports all-zero components.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (tan_degenerate || bin_degenerate) |->
            (!tan_degenerate || (tan_x == 0 && tan_y == 0 && tan_z == 0)) &&
            (!bin_degenerate || (bin_x == 0 && bin_y == 0 && bin_z == 0)))
        else $error("degenerate vector has nonzero components");

    // A vector of nonzero length never normalizes to all zeros.
    a_nonzero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |->
            (tan_degenerate || tan_x != 0 || tan_y != 0 || tan_z != 0) &&
            (bin_degenerate || bin_x != 0 || bin_y != 0 || bin_z != 0))
        else $error("nonzero vector normalized to zero");

endmodule

// ===== design/ttb_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side payload.
module ttb_isqrt #(
    parameter int IW = 62,
    parameter int PW = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IW-1:0]     radicand,
    input  logic [PW-1:0]     in_payload,
    output logic              out_valid,
    output logic [IW/2-1:0]   root,
    output logic [PW-1:0]     out_payload
);

    localparam int OW = IW / 2;
    localparam int RW = OW + 3;

    logic            vld_reg  [OW];
    logic [IW-1:0]   rad_reg  [OW];
    logic [RW-1:0]   rem_reg  [OW];
    logic [OW-1:0]   root_reg [OW];
    logic [PW-1:0]   pay_reg  [OW];

    for (genvar j = 0; j < OW; j++) begin : g_stage
        logic          vld_prev;
        logic [IW-1:0] rad_prev;
        logic [RW-1:0] rem_prev;
        logic [OW-1:0] root_prev;
        logic [PW-1:0] pay_prev;
        logic [RW-1:0] rem_shift;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [OW-1:0] root_next;
        logic [IW-1:0] rad_next;

        if (j == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign pay_prev  = in_payload;
        end
        else begin : g_rest
            assign vld_prev  = vld_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign pay_prev  = pay_reg[j-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        always_comb
        begin
            rem_shift = {rem_prev[RW-3:0], rad_prev[IW-1 -: 2]};
            trial     = {{(RW-OW-2){1'b0}}, root_prev, 2'b01};
            rad_next  = {rad_prev[IW-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_prev[OW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_prev[OW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[j]  <= rad_next;
            rem_reg[j]  <= rem_next;
            root_reg[j] <= root_next;
            pay_reg[j]  <= pay_prev;
        end
    end

    assign out_valid   = vld_reg[OW-1];
    assign root        = root_reg[OW-1];
    assign out_payload = pay_reg[OW-1];

endmodule

// ===== design/ttb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
module ttb_div #(
    parameter int LANES = 3,
    parameter int NUMW  = 45,
    parameter int DW    = 31,
    parameter int QW    = 15,
    parameter int PW    = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUMW-1:0]  dividend,
    input  logic [DW-1:0]               divisor,
    input  logic [PW-1:0]               in_payload,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quot,
    output logic [PW-1:0]               out_payload
);

    logic                       vld_reg [QW];
    logic [LANES-1:0][NUMW-1:0] rem_reg [QW];
    logic [LANES-1:0][QW-1:0]   quo_reg [QW];
    logic [DW-1:0]              div_reg [QW];
    logic [PW-1:0]              pay_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int SH = QW - 1 - j;

        logic                       vld_prev;
        logic [LANES-1:0][NUMW-1:0] rem_prev;
        logic [LANES-1:0][QW-1:0]   quo_prev;
        logic [DW-1:0]              div_prev;
        logic [PW-1:0]              pay_prev;
        logic [NUMW-1:0]            div_shift;
        logic [LANES-1:0][NUMW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0]   quo_next;

        if (j == 0) begin : g_first
            assign vld_prev = in_valid;
            assign rem_prev = dividend;
            assign quo_prev = '0;
            assign div_prev = divisor;
            assign pay_prev = in_payload;
        end
        else begin : g_rest
            assign vld_prev = vld_reg[j-1];
            assign rem_prev = rem_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign div_prev = div_reg[j-1];
            assign pay_prev = pay_reg[j-1];
        end

        always_comb
        begin
            div_shift = NUMW'(div_prev) << SH;
            for (int i = 0; i < LANES; i++)
            begin
                if (rem_prev[i] >= div_shift)
                begin
                    rem_next[i] = rem_prev[i] - div_shift;
                    quo_next[i] = {quo_prev[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_prev[i];
                    quo_next[i] = {quo_prev[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            quo_reg[j] <= quo_next;
            div_reg[j] <= div_prev;
            pay_reg[j] <= pay_prev;
        end
    end

    assign out_valid   = vld_reg[QW-1];
    assign quot        = quo_reg[QW-1];
    assign out_payload = pay_reg[QW-1];

endmodule

// ===== design/ttb_front.sv =====
// Front end: edge vectors, UV deltas, cross products and sign/magnitude split.
module ttb_front
    import ttb_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [2:0][2:0][CW-1:0]        pos,
    input  logic [2:0][UVP_W-1:0]          uv,
    output logic                           out_valid,
    output logic [2:0][CW+UV_W+2:0]        tan_mag,
    output logic [2:0]                     tan_neg,
    output logic [2:0][CW+UV_W+2:0]        bin_mag,
    output logic [2:0]                     bin_neg
);

    localparam int EW  = CW + 1;
    localparam int DLW = UV_W + 1;
    localparam int PRW = EW + DLW;
    localparam int TW  = PRW + 1;

    function automatic logic signed [PRW-1:0] smul(input logic signed [EW-1:0] a,
                                                   input logic signed [DLW-1:0] b);
        return a * b;
    endfunction

    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;

    // Differences.
    logic [2:0][EW-1:0] e1_next, e2_next, e1_reg, e2_reg;
    logic [DLW-1:0]     du1_next, dv1_next, du2_next, dv2_next;
    logic [DLW-1:0]     du1_reg, dv1_reg, du2_reg, dv2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i] = {pos[1][i][CW-1], pos[1][i]} - {pos[0][i][CW-1], pos[0][i]};
            e2_next[i] = {pos[2][i][CW-1], pos[2][i]} - {pos[0][i][CW-1], pos[0][i]};
        end
        du1_next = {uv[1][UV_W-1], uv[1][UV_W-1:0]} - {uv[0][UV_W-1], uv[0][UV_W-1:0]};
        du2_next = {uv[2][UV_W-1], uv[2][UV_W-1:0]} - {uv[0][UV_W-1], uv[0][UV_W-1:0]};
        dv1_next = {uv[1][UVP_W-1], uv[1][UVP_W-1:UV_W]}
                 - {uv[0][UVP_W-1], uv[0][UVP_W-1:UV_W]};
        dv2_next = {uv[2][UVP_W-1], uv[2][UVP_W-1:UV_W]}
                 - {uv[0][UVP_W-1], uv[0][UVP_W-1:UV_W]};
    end

    // Products: tangent terms e1*dv2 and e2*dv1, binormal terms e2*du1 and e1*du2.
    logic [2:0][PRW-1:0] ta_next, tb_next, ba_next, bb_next;
    logic [2:0][PRW-1:0] ta_reg, tb_reg, ba_reg, bb_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ta_next[i] = smul(e1_reg[i], dv2_reg);
            tb_next[i] = smul(e2_reg[i], dv1_reg);
            ba_next[i] = smul(e2_reg[i], du1_reg);
            bb_next[i] = smul(e1_reg[i], du2_reg);
        end
    end

    // Differences of products, carried one bit wider so nothing wraps.
    logic [2:0][TW-1:0] tv_next, bv_next, tv_reg, bv_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tv_next[i] = {ta_reg[i][PRW-1], ta_reg[i]} - {tb_reg[i][PRW-1], tb_reg[i]};
            bv_next[i] = {ba_reg[i][PRW-1], ba_reg[i]} - {bb_reg[i][PRW-1], bb_reg[i]};
        end
    end

    // Sign and magnitude.
    logic [2:0][TW-1:0] tm_next, bm_next, tm_reg, bm_reg;
    logic [2:0]         tn_next, bn_next, tn_reg, bn_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tn_next[i] = tv_reg[i][TW-1];
            bn_next[i] = bv_reg[i][TW-1];
            tm_next[i] = tn_next[i] ? (TW'(0) - tv_reg[i]) : tv_reg[i];
            bm_next[i] = bn_next[i] ? (TW'(0) - bv_reg[i]) : bv_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg  <= e1_next;
        e2_reg  <= e2_next;
        du1_reg <= du1_next;
        dv1_reg <= dv1_next;
        du2_reg <= du2_next;
        dv2_reg <= dv2_next;
        ta_reg  <= ta_next;
        tb_reg  <= tb_next;
        ba_reg  <= ba_next;
        bb_reg  <= bb_next;
        tv_reg  <= tv_next;
        bv_reg  <= bv_next;
        tm_reg  <= tm_next;
        bm_reg  <= bm_next;
        tn_reg  <= tn_next;
        bn_reg  <= bn_next;
    end

    assign out_valid = vld_d_reg;
    assign tan_mag   = tm_reg;
    assign tan_neg   = tn_reg;
    assign bin_mag   = bm_reg;
    assign bin_neg   = bn_reg;

endmodule

// ===== design/ttb_unit.sv =====
// Normalizes one 3-component vector to unit length in signed Q2.14.
module ttb_unit
    import ttb_pkg::*;
#(
    parameter int MW = 35
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [2:0][MW-1:0]      mag,
    input  logic [2:0]              neg,
    output unit_status_t            status,
    output logic [2:0][UNIT_W-1:0]  comp
);

    localparam int NW = (MW > SCALE_W) ? MW : SCALE_W;
    localparam int SL = $clog2(NW);

    // Leading-one normalizer: one binary shift step per stage, largest first.
    logic               nrm_vld_reg  [SL];
    logic [2:0][NW-1:0] nrm_word_reg [SL];
    vec_tag_t           nrm_tag_reg  [SL];

    for (genvar j = 0; j < SL; j++) begin : g_nrm
        localparam int SH = 1 << (SL - 1 - j);

        logic               vld_prev;
        logic [2:0][NW-1:0] word_prev;
        vec_tag_t           tag_prev;
        logic [NW-1:0]      or_word;
        logic               hit;
        logic [2:0][NW-1:0] word_next;

        if (j == 0) begin : g_first
            assign vld_prev      = in_valid;
            assign tag_prev.neg  = neg;
            assign tag_prev.zero = ~|(mag[0] | mag[1] | mag[2]);
            for (genvar i = 0; i < 3; i++) begin : g_ext
                assign word_prev[i] = NW'(mag[i]);
            end
        end
        else begin : g_rest
            assign vld_prev  = nrm_vld_reg[j-1];
            assign word_prev = nrm_word_reg[j-1];
            assign tag_prev  = nrm_tag_reg[j-1];
        end

        always_comb
        begin
            or_word = word_prev[0] | word_prev[1] | word_prev[2];
            hit     = |or_word[NW-1 -: SH];
            for (int i = 0; i < 3; i++)
            begin
                word_next[i] = hit ? word_prev[i] : (word_prev[i] << SH);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nrm_vld_reg[j] <= 1'b0;
            end
            else
            begin
                nrm_vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            nrm_word_reg[j] <= word_next;
            nrm_tag_reg[j]  <= tag_prev;
        end
    end

    // The top SCALE_W bits of the left-justified word are the scaled magnitudes.
    logic [2:0][SCALE_W-1:0] scaled;
    logic [2:0][SQ_W-1:0]    sq_next, sq_reg;
    sq_pay_t                 sq_pay_next, sq_pay_reg;
    logic                    sq_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled[i]  = nrm_word_reg[SL-1][i][NW-1 -: SCALE_W];
            sq_next[i] = SQ_W'(scaled[i]) * SQ_W'(scaled[i]);
        end
        sq_pay_next.tag = nrm_tag_reg[SL-1];
        sq_pay_next.s   = scaled;
    end

    logic [SUM_W-1:0] sum_next, sum_reg;
    sq_pay_t          sum_pay_reg;
    logic             sum_vld_reg;

    assign sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg  <= nrm_vld_reg[SL-1];
            sum_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg      <= sq_next;
        sq_pay_reg  <= sq_pay_next;
        sum_reg     <= sum_next;
        sum_pay_reg <= sq_pay_reg;
    end

    // Length: floor of the square root of the sum of squares.
    logic                     rt_vld;
    logic [ROOT_W-1:0]        rt_root;
    logic [$bits(sq_pay_t)-1:0] rt_pay_bits;
    sq_pay_t                  rt_pay;

    ttb_isqrt #(
        .IW (SUM_W),
        .PW ($bits(sq_pay_t))
    ) u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sum_vld_reg),
        .radicand    (sum_reg),
        .in_payload  (sum_pay_reg),
        .out_valid   (rt_vld),
        .root        (rt_root),
        .out_payload (rt_pay_bits)
    );

    assign rt_pay = rt_pay_bits;

    // Rounded quotient numerators: mag * 2^14 + floor(L / 2).
    logic [2:0][NUM_W-1:0] num_next, num_reg;
    logic [ROOT_W-1:0]     num_root_reg;
    vec_tag_t              num_tag_reg;
    logic                  num_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = (NUM_W'(rt_pay.s[i]) << FRAC_BITS) + NUM_W'(rt_root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vld_reg <= 1'b0;
        end
        else
        begin
            num_vld_reg <= rt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        num_root_reg <= rt_root;
        num_tag_reg  <= rt_pay.tag;
    end

    logic                          dv_vld;
    logic [2:0][QUOT_W-1:0]        dv_quot;
    logic [$bits(vec_tag_t)-1:0]   dv_tag_bits;
    vec_tag_t                      dv_tag;

    ttb_div #(
        .LANES (3),
        .NUMW  (NUM_W),
        .DW    (ROOT_W),
        .QW    (QUOT_W),
        .PW    ($bits(vec_tag_t))
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (num_vld_reg),
        .dividend    (num_reg),
        .divisor     (num_root_reg),
        .in_payload  (num_tag_reg),
        .out_valid   (dv_vld),
        .quot        (dv_quot),
        .out_payload (dv_tag_bits)
    );

    assign dv_tag = dv_tag_bits;

    // Clamp, restore the sign, and force zero for a zero-length vector.
    logic [2:0][QUOT_W-1:0] clamped;
    logic [2:0][UNIT_W-1:0] comp_next, comp_reg;
    logic                   out_vld_reg;
    logic                   out_degen_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clamped[i] = (dv_quot[i] > QUOT_W'(UNIT_ONE)) ? QUOT_W'(UNIT_ONE) : dv_quot[i];
            if (dv_tag.zero)
            begin
                comp_next[i] = '0;
            end
            else if (dv_tag.neg[i])
            begin
                comp_next[i] = UNIT_W'(0) - UNIT_W'(clamped[i]);
            end
            else
            begin
                comp_next[i] = UNIT_W'(clamped[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg      <= comp_next;
        out_degen_reg <= dv_tag.zero;
    end

    assign status.valid      = out_vld_reg;
    assign status.degenerate = out_degen_reg;
    assign comp              = comp_reg;

endmodule

// ===== verif/tb_triangle_tangent_binormal.sv =====
// Self-checking testbench for the triangle tangent/binormal unit.
`timescale 1ns / 100ps

module tb_triangle_tangent_binormal;
    import ttb_pkg::*;

    // The unit is built at its default coordinate width.
    localparam int COORD_W = 16;

    // The drain after the last result and the wait for outstanding results
    // both run well beyond the time the unit takes to answer a request.
    localparam int DRAIN_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 2000;

    // Thresholds of the magnitude scaling done before the square root.
    localparam longint unsigned SCALE_HI = 64'd1 << 30;
    localparam longint unsigned SCALE_LO = 64'd1 << 29;

    // One triangle request, index 0..2 selects the vertex.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] x;
        logic [2:0][COORD_W-1:0] y;
        logic [2:0][COORD_W-1:0] z;
        logic [2:0][UVP_W-1:0]   uv;
    } triangle_t;

    // One unit vector in Q2.14, index 0..2 is x, y, z.
    typedef struct packed {
        logic [2:0][UNIT_W-1:0] c;
        logic                   zero;
    } unit_vec_t;

    // What one triangle is expected to produce.
    typedef struct packed {
        unit_vec_t tangent;
        unit_vec_t binormal;
    } frame_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [COORD_W-1:0]  p0_x, p0_y, p0_z;
    logic signed [COORD_W-1:0]  p1_x, p1_y, p1_z;
    logic signed [COORD_W-1:0]  p2_x, p2_y, p2_z;
    logic [UVP_W-1:0]           uv0_packed, uv1_packed, uv2_packed;
    logic                       done;
    logic signed [UNIT_W-1:0]   tan_x, tan_y, tan_z;
    logic signed [UNIT_W-1:0]   bin_x, bin_y, bin_z;
    logic                       tan_degenerate;
    logic                       bin_degenerate;

    // Expected frames of the triangles taken so far, oldest first.
    frame_t pending_frames[$];
    int     mismatch_count = 0;
    int     result_index   = 0;

    // When set, the request side may leave cycles empty between triangles.
    bit     allow_idle = 1'b1;

    triangle_tangent_binormal #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .p0_x           (p0_x),
        .p0_y           (p0_y),
        .p0_z           (p0_z),
        .p1_x           (p1_x),
        .p1_y           (p1_y),
        .p1_z           (p1_z),
        .p2_x           (p2_x),
        .p2_y           (p2_y),
        .p2_z           (p2_z),
        .uv0_packed     (uv0_packed),
        .uv1_packed     (uv1_packed),
        .uv2_packed     (uv2_packed),
        .done           (done),
        .tan_x          (tan_x),
        .tan_y          (tan_y),
        .tan_z          (tan_z),
        .bin_x          (bin_x),
        .bin_y          (bin_y),
        .bin_z          (bin_z),
        .tan_degenerate (tan_degenerate),
        .bin_degenerate (bin_degenerate)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Integer square root, rounded down, found one result bit at a time.
    // The sums seen here stay below 2^62, so the root fits in 31 bits and
    // the trial square never overflows.
    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= s)
                root = trial;
        end
        return root;
    endfunction

    // Scales a raw vector (units of 2^-20) to unit length in Q2.14. The
    // magnitudes are first brought so that the largest has its leading one
    // at bit 29, shifting right with truncation or left as needed; each
    // component is then divided by the rounded-down length with rounding.
    function automatic unit_vec_t to_unit(longint a, longint b, longint c);
        longint          comp[3];
        longint unsigned mag[3];
        logic [2:0]      neg;
        longint unsigned peak;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        logic [UNIT_W-1:0] q16;
        unit_vec_t       r;
        comp[0] = a;
        comp[1] = b;
        comp[2] = c;
        peak = 0;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = comp[i] < 0;
            mag[i] = neg[i] ? longint'(-comp[i]) : longint'(comp[i]);
            if (mag[i] > peak)
                peak = mag[i];
        end
        // A zero-length vector reports zero components and the flag.
        if (peak == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        while (peak >= SCALE_HI)
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
            peak = peak >> 1;
        end
        while (peak < SCALE_LO)
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
            peak = peak << 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * UNIT_ONE + (len >> 1)) / len;
            if (q > UNIT_ONE)
                q = UNIT_ONE;
            q16 = q[UNIT_W-1:0];
            r.c[i] = neg[i] ? -q16 : q16;
        end
        return r;
    endfunction

    // Expected frame of one triangle. Edges and UV deltas are carried at
    // full width, and the determinant is left out, so a mirrored u keeps the
    // sign of the tangent and a mirrored v keeps the sign of the binormal.
    function automatic frame_t predict_frame(triangle_t t);
        longint px[3], py[3], pz[3], u[3], v[3];
        longint du1, dv1, du2, dv2;
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        frame_t f;
        for (int k = 0; k < 3; k++)
        begin
            px[k] = $signed(t.x[k]);
            py[k] = $signed(t.y[k]);
            pz[k] = $signed(t.z[k]);
            u[k]  = $signed(t.uv[k][UV_W-1:0]);
            v[k]  = $signed(t.uv[k][UVP_W-1:UV_W]);
        end
        du1 = u[1] - u[0];
        dv1 = v[1] - v[0];
        du2 = u[2] - u[0];
        dv2 = v[2] - v[0];
        e1x = px[1] - px[0];
        e1y = py[1] - py[0];
        e1z = pz[1] - pz[0];
        e2x = px[2] - px[0];
        e2y = py[2] - py[0];
        e2z = pz[2] - pz[0];
        f.tangent  = to_unit(e1x * dv2 - e2x * dv1, e1y * dv2 - e2y * dv1,
                             e1z * dv2 - e2z * dv1);
        f.binormal = to_unit(e2x * du1 - e1x * du2, e2y * du1 - e1y * du2,
                             e2z * du1 - e1z * du2);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [UVP_W-1:0] pack_uv(int u, int v);
        return {v[UV_W-1:0], u[UV_W-1:0]};
    endfunction

    function automatic triangle_t make_triangle(int x0, int y0, int z0,
                                                int x1, int y1, int z1,
                                                int x2, int y2, int z2,
                                                logic [UVP_W-1:0] uv0,
                                                logic [UVP_W-1:0] uv1,
                                                logic [UVP_W-1:0] uv2);
        triangle_t t;
        t.x  = {x2[COORD_W-1:0], x1[COORD_W-1:0], x0[COORD_W-1:0]};
        t.y  = {y2[COORD_W-1:0], y1[COORD_W-1:0], y0[COORD_W-1:0]};
        t.z  = {z2[COORD_W-1:0], z1[COORD_W-1:0], z0[COORD_W-1:0]};
        t.uv = {uv2, uv1, uv0};
        return t;
    endfunction

    // A 16-bit value in one of three styles: any value, a small value near
    // zero (so the scaling shifts left a long way), or a range corner.
    function automatic logic [15:0] random_word(int unsigned style);
        int          small_val;
        logic [15:0] corners[5];
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        small_val = int'($urandom_range(0, 15)) - 8;
        case (style)
            0: return 16'($urandom);
            1: return small_val[15:0];
            default: return corners[$urandom_range(0, 4)];
        endcase
    endfunction

    // Random triangle. Most are fully random; some take small values or
    // range corners, and about one in five is given a shape that zeroes one
    // or both vectors.
    function automatic triangle_t random_triangle();
        triangle_t   t;
        int unsigned pick;
        int unsigned style;
        pick = $urandom_range(0, 99);
        style = (pick < 55) ? 0 : (pick < 80) ? 1 : 2;
        for (int k = 0; k < 3; k++)
        begin
            t.x[k]  = random_word(style);
            t.y[k]  = random_word(style);
            t.z[k]  = random_word(style);
            t.uv[k] = {random_word(style), random_word(style)};
        end
        case ($urandom_range(0, 14))
            0:
            begin
                // Every v equal: no tangent.
                t.uv[1][UVP_W-1:UV_W] = t.uv[0][UVP_W-1:UV_W];
                t.uv[2][UVP_W-1:UV_W] = t.uv[0][UVP_W-1:UV_W];
            end
            1:
            begin
                // Every u equal: no binormal.
                t.uv[1][UV_W-1:0] = t.uv[0][UV_W-1:0];
                t.uv[2][UV_W-1:0] = t.uv[0][UV_W-1:0];
            end
            2:
            begin
                // All three vertices at one point: neither vector exists.
                t.x[1] = t.x[0];
                t.x[2] = t.x[0];
                t.y[1] = t.y[0];
                t.y[2] = t.y[0];
                t.z[1] = t.z[0];
                t.z[2] = t.z[0];
            end
            default: ;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one triangle. Inputs change only at the falling edge; start is
    // left high after the request is taken so that back-to-back triangles
    // keep it high, and it is only lowered on an idle cycle or at the end.
    task automatic send_triangle(triangle_t t);
        @(negedge clk);
        while (allow_idle && $urandom_range(0, 99) < 34)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        p0_x = t.x[0];
        p0_y = t.y[0];
        p0_z = t.z[0];
        p1_x = t.x[1];
        p1_y = t.y[1];
        p1_z = t.z[1];
        p2_x = t.x[2];
        p2_y = t.y[2];
        p2_z = t.z[2];
        uv0_packed = t.uv[0];
        uv1_packed = t.uv[1];
        uv2_packed = t.uv[2];
        start = 1'b1;
        // The request is taken at the first rising edge with busy low.
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_frames = {pending_frames, predict_frame(t)};
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_word(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                    result_index, name, $signed(got), $signed(want)));
    endtask

    // A result is shown for one cycle with done high and must be taken at
    // the rising edge that ends that cycle. Sampling here sees the values
    // from before the edge, since the unit updates them after it.
    always @(posedge clk)
    begin : check_results
        frame_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_frames.size() == 0)
            begin
                note_mismatch($sformatf("result %0d arrived with no request outstanding",
                                        result_index));
            end
            else
            begin
                want = pending_frames.pop_front();
                check_word("tan_x", tan_x, want.tangent.c[0]);
                check_word("tan_y", tan_y, want.tangent.c[1]);
                check_word("tan_z", tan_z, want.tangent.c[2]);
                check_word("bin_x", bin_x, want.binormal.c[0]);
                check_word("bin_y", bin_y, want.binormal.c[1]);
                check_word("bin_z", bin_z, want.binormal.c[2]);
                check_word("tan_degenerate", {15'd0, tan_degenerate},
                           {15'd0, want.tangent.zero});
                check_word("bin_degenerate", {15'd0, bin_degenerate},
                           {15'd0, want.binormal.zero});
            end
            result_index++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A triangle with every field zero has neither vector.
    task automatic test_zero_triangle();
        send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0,
                                    pack_uv(0, 0), pack_uv(0, 0), pack_uv(0, 0)));
    endtask

    // Range corners of positions and UVs: the widest edges and deltas, so
    // the products need every bit and the scaling shifts right the most.
    task automatic test_range_extremes();
        send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                                    32767, -32768, 0,
                                    pack_uv(-32768, -32768), pack_uv(32767, 32767),
                                    pack_uv(32767, -32768)));
        send_triangle(make_triangle(32767, 32767, 32767, -32768, -32768, -32768,
                                    -32768, 32767, -1,
                                    pack_uv(32767, 32767), pack_uv(-32768, -32768),
                                    pack_uv(-32768, 32767)));
        send_triangle(make_triangle(-32768, 0, 32767, 32767, -32768, 0,
                                    0, 32767, -32768,
                                    pack_uv(-32768, 32767), pack_uv(0, -32768),
                                    pack_uv(32767, 0)));
        send_triangle(make_triangle(-1, -1, -1, -1, -1, -1, -1, -1, -1,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_triangle(make_triangle(32767, 32767, 32767, -32768, -32768, -32768,
                                    32767, 32767, 32767,
                                    32'h7FFF_8000, 32'h8000_7FFF, 32'h0000_0000));
        // The smallest nonzero vectors: the scaling shifts left the most.
        send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0,
                                    pack_uv(0, 0), pack_uv(1, 0), pack_uv(0, 1)));
        send_triangle(make_triangle(5, -3, 7, 5, -3, 8, 5, -2, 7,
                                    pack_uv(3, 3), pack_uv(3, 4), pack_uv(4, 3)));
    endtask

    // One vector zero while the other exists, and both zero with nonzero
    // UVs and positions.
    task automatic test_degenerate_vectors();
        // Every v the same: the tangent vanishes.
        send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0,
                                    pack_uv(0, 100), pack_uv(4096, 100),
                                    pack_uv(-4096, 100)));
        // Every u the same: the binormal vanishes.
        send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0,
                                    pack_uv(-77, 0), pack_uv(-77, 4096),
                                    pack_uv(-77, -4096)));
        // Coincident vertices: both vanish.
        send_triangle(make_triangle(1000, -2000, 3000, 1000, -2000, 3000,
                                    1000, -2000, 3000,
                                    pack_uv(1, 2), pack_uv(300, -400),
                                    pack_uv(-5000, 6000)));
        // Collinear vertices with matching UV steps: both vanish.
        send_triangle(make_triangle(0, 0, 0, 100, 200, -300, 200, 400, -600,
                                    pack_uv(0, 0), pack_uv(50, 70), pack_uv(100, 140)));
    endtask

    // An axis-aligned unit triangle with normal and mirrored UVs. Without
    // the determinant the mirrored u flips only the binormal.
    task automatic test_mirrored_uv();
        send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0,
                                    pack_uv(0, 0), pack_uv(4096, 0), pack_uv(0, 4096)));
        send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0,
                                    pack_uv(0, 0), pack_uv(-4096, 0), pack_uv(0, 4096)));
        send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0,
                                    pack_uv(0, 0), pack_uv(4096, 0), pack_uv(0, -4096)));
        // A tilted triangle whose components land between the grid points.
        send_triangle(make_triangle(300, -200, 100, 812, 57, -400, -91, 640, 333,
                                    pack_uv(1024, 2048), pack_uv(3000, 1500),
                                    pack_uv(500, 3900)));
    endtask

    // Random triangles issued on every cycle, with no idle cycle at all.
    task automatic test_back_to_back(int count);
        allow_idle = 1'b0;
        repeat (count)
            send_triangle(random_triangle());
        allow_idle = 1'b1;
    endtask

    // Random triangles with idle cycles falling at random.
    task automatic test_random_mix(int count);
        repeat (count)
            send_triangle(random_triangle());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        p0_x = '0;
        p0_y = '0;
        p0_z = '0;
        p1_x = '0;
        p1_y = '0;
        p1_z = '0;
        p2_x = '0;
        p2_y = '0;
        p2_z = '0;
        uv0_packed = '0;
        uv1_packed = '0;
        uv2_packed = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_triangle();
        test_range_extremes();
        test_degenerate_vectors();
        test_mirrored_uv();
        test_back_to_back(150);
        test_random_mix(650);

        // Stop requesting, then let every outstanding result arrive.
        @(negedge clk);
        start = 1'b0;
        for (int n = 0; n < SETTLE_CYCLES && pending_frames.size() != 0; n++)
            @(posedge clk);
        // Extra cycles catch any result the unit produces beyond the last.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_frames.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived",
                                    pending_frames.size()));

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // This bound lies far beyond what a correct run needs.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/ttb_pkg.sv
design/ttb_isqrt.sv
design/ttb_div.sv
design/ttb_front.sv
design/ttb_unit.sv
design/triangle_tangent_binormal.sv
verif/tb_triangle_tangent_binormal.sv
